// ===== hdl/matrix_multiply_engine_assert.svh =====
// Assertion macros for the matrix multiply engine.
// Each macro expects clk and arst_n in scope.
`ifndef MATRIX_MULTIPLY_ENGINE_ASSERT_SVH
`define MATRIX_MULTIPLY_ENGINE_ASSERT_SVH

`ifndef ASSERT_OFF
`define MME_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("mme: same-cycle check failed");
`define MME_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("mme: next-cycle check failed");
`else
`define MME_ASSERT_IMP(lbl, ante, cons)
`define MME_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// ===== hdl/mme_pkg.sv =====
package mme_pkg;

	localparam int MAX_DIM    = 8;
	localparam int ELEM_WIDTH = 16;

	localparam int IDX_W   = $clog2(MAX_DIM);
	localparam int ADDR_W  = $clog2(MAX_DIM * MAX_DIM);
	localparam int CNT_W   = $clog2(MAX_DIM + 1);
	localparam int DIM_W   = 4;
	localparam int POS_W   = 3;
	localparam int VAL_W   = 16;
	localparam int PROD_W  = 36;
	localparam int MUL_W   = 2 * ELEM_WIDTH;
	localparam int CFG_RESET = 8;

	typedef enum logic [1:0] {
		OP_LOAD_A  = 2'd0,
		OP_LOAD_B  = 2'd1,
		OP_COMPUTE = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		CFG_ROWS_A    = 2'd0,
		CFG_INNER_LEN = 2'd1,
		CFG_COLS_B    = 2'd2
	} cfg_idx_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ISSUE,
		ST_DRAIN,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic [1:0]              op;
		logic [POS_W-1:0]        row;
		logic [POS_W-1:0]        col;
		logic signed [VAL_W-1:0] value;
	} in_item_t;

	typedef struct packed {
		logic [POS_W-1:0]         out_row;
		logic [POS_W-1:0]         out_col;
		logic signed [PROD_W-1:0] product_value;
		logic                     last;
	} out_item_t;

	typedef struct packed {
		logic              load_a;
		logic              load_b;
		logic [ADDR_W-1:0] wr_addr;
		logic              issue;
		logic              first;
		logic              lastk;
		logic [ADDR_W-1:0] rd_a_addr;
		logic [ADDR_W-1:0] rd_b_addr;
		logic              emit;
		logic [POS_W-1:0]  emit_row;
		logic [POS_W-1:0]  emit_col;
		logic              emit_last;
	} cmd_t;

	typedef struct packed {
		logic sum_ready;
		logic out_free;
	} stat_t;

	function automatic logic [ADDR_W-1:0] elem_addr(input logic [IDX_W-1:0] r,
			input logic [IDX_W-1:0] c);
		elem_addr = ADDR_W'(r) * ADDR_W'(MAX_DIM) + ADDR_W'(c);
	endfunction

	function automatic logic [CNT_W-1:0] clamp_dim(input logic [DIM_W-1:0] d);
		if (d == '0) begin
			clamp_dim = CNT_W'(1);
		end else if (int'(d) > MAX_DIM) begin
			clamp_dim = CNT_W'(MAX_DIM);
		end else begin
			clamp_dim = CNT_W'(d);
		end
	endfunction

endpackage

// ===== hdl/matrix_multiply_engine.sv =====
// Fixed-point matrix product engine. Load items (op load A / load B) write one
// signed Q8.8 element at (row, col) and are taken one per cycle whenever the
// engine is idle; a row or col beyond the 8x8 stores drops the write. A compute
// item sweeps the product rows_a x cols_b in row-major order and emits one item
// per element with the exact Q20.16 sum over inner_len terms; the final element
// has last set. Op code 3 is taken and dropped. For each product element the
// sequencer issues inner_len multiply-accumulates, one per cycle, through the
// single shared multiplier and the one read port of each store, then drains the
// read/multiply/accumulate pipeline and loads the output register. A compute
// item keeps the engine busy until its last element is emitted, and an output
// stall holds the sweep. A dimension register of zero acts as 1, above 8 as 8.
// Write configuration only while idle. Elements read by a compute must have
// been loaded since reset.
module matrix_multiply_engine (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  mme_pkg::in_item_t           in_item,
	output logic                        out_valid,
	input  logic                        out_ready,
	output mme_pkg::out_item_t          out_item,
	input  logic                        cfg_wr_en,
	input  logic [1:0]                  cfg_index,
	input  logic [mme_pkg::DIM_W-1:0]   cfg_wr_data
);

`include "matrix_multiply_engine_assert.svh"

	// command and status between sequencer and datapath
	mme_pkg::cmd_t  cmd;
	mme_pkg::stat_t stat;

	// a compute item taken at this edge
	logic compute_taken;

	assign compute_taken = in_valid && in_ready && (in_item.op == mme_pkg::OP_COMPUTE);

	// sequencer: owns the dimension registers and the i/j/k sweep counters
	mme_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.in_item     (in_item),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_wr_data (cfg_wr_data),
		.stat        (stat),
		.cmd         (cmd)
	);

	// datapath: element stores, multiplier, accumulator and output register
	mme_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.value     (in_item.value),
		.stat      (stat),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.out_item  (out_item)
	);

	// a taken compute item must close the input until the sweep ends
	`MME_ASSERT_NXT(a_compute_blocks_input, compute_taken, !in_ready)
	// never overwrite an item still waiting in the output register
	`MME_ASSERT_IMP(a_emit_has_room, cmd.emit, stat.out_free)
	// a finished sum arrives only while the sweep is draining
	`MME_ASSERT_IMP(a_sum_only_in_drain, stat.sum_ready, !cmd.issue && !in_ready)
	// an emit shows up at the output on the next cycle
	`MME_ASSERT_NXT(a_emit_reaches_port, cmd.emit, out_valid)

endmodule

// ===== hdl/mme_ctrl.sv =====
module mme_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  mme_pkg::in_item_t           in_item,
	input  logic                        cfg_wr_en,
	input  logic [1:0]                  cfg_index,
	input  logic [mme_pkg::DIM_W-1:0]   cfg_wr_data,
	input  mme_pkg::stat_t              stat,
	output mme_pkg::cmd_t               cmd
);

	mme_pkg::state_t state_q, state_d;

	logic [mme_pkg::DIM_W-1:0] rows_a_q, inner_len_q, cols_b_q;
	logic [mme_pkg::IDX_W-1:0] i_q, j_q, k_q;
	logic [mme_pkg::IDX_W-1:0] r_last, k_last, c_last;
	logic                      accept, in_range, lastk, last_elem;

	assign r_last = mme_pkg::IDX_W'(mme_pkg::clamp_dim(rows_a_q) - 1'b1);
	assign k_last = mme_pkg::IDX_W'(mme_pkg::clamp_dim(inner_len_q) - 1'b1);
	assign c_last = mme_pkg::IDX_W'(mme_pkg::clamp_dim(cols_b_q) - 1'b1);

	assign accept    = in_valid && in_ready;
	assign in_range  = (int'(in_item.row) < mme_pkg::MAX_DIM) &&
		(int'(in_item.col) < mme_pkg::MAX_DIM);
	assign lastk     = (k_q == k_last);
	assign last_elem = (i_q == r_last) && (j_q == c_last);

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_a_q    <= mme_pkg::DIM_W'(mme_pkg::CFG_RESET);
			inner_len_q <= mme_pkg::DIM_W'(mme_pkg::CFG_RESET);
			cols_b_q    <= mme_pkg::DIM_W'(mme_pkg::CFG_RESET);
		end else if (cfg_wr_en) begin
			case (cfg_index)
				mme_pkg::CFG_ROWS_A:    rows_a_q    <= cfg_wr_data;
				mme_pkg::CFG_INNER_LEN: inner_len_q <= cfg_wr_data;
				mme_pkg::CFG_COLS_B:    cols_b_q    <= cfg_wr_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			mme_pkg::ST_IDLE: begin
				if (accept && in_item.op == mme_pkg::OP_COMPUTE) state_d = mme_pkg::ST_ISSUE;
			end
			mme_pkg::ST_ISSUE: begin
				if (lastk) state_d = mme_pkg::ST_DRAIN;
			end
			mme_pkg::ST_DRAIN: begin
				if (stat.sum_ready) state_d = mme_pkg::ST_EMIT;
			end
			mme_pkg::ST_EMIT: begin
				if (stat.out_free) state_d = last_elem ? mme_pkg::ST_IDLE : mme_pkg::ST_ISSUE;
			end
			default: state_d = mme_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready      = (state_q == mme_pkg::ST_IDLE);
		cmd           = '0;
		cmd.load_a    = accept && in_range && (in_item.op == mme_pkg::OP_LOAD_A);
		cmd.load_b    = accept && in_range && (in_item.op == mme_pkg::OP_LOAD_B);
		cmd.wr_addr   = mme_pkg::elem_addr(mme_pkg::IDX_W'(in_item.row),
			mme_pkg::IDX_W'(in_item.col));
		cmd.issue     = (state_q == mme_pkg::ST_ISSUE);
		cmd.first     = (k_q == '0);
		cmd.lastk     = lastk;
		cmd.rd_a_addr = mme_pkg::elem_addr(i_q, k_q);
		cmd.rd_b_addr = mme_pkg::elem_addr(k_q, j_q);
		cmd.emit      = (state_q == mme_pkg::ST_EMIT) && stat.out_free;
		cmd.emit_row  = mme_pkg::POS_W'(i_q);
		cmd.emit_col  = mme_pkg::POS_W'(j_q);
		cmd.emit_last = last_elem;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mme_pkg::ST_IDLE;
			i_q     <= '0;
			j_q     <= '0;
			k_q     <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == mme_pkg::ST_IDLE) begin
				i_q <= '0;
				j_q <= '0;
				k_q <= '0;
			end else if (state_q == mme_pkg::ST_ISSUE) begin
				k_q <= lastk ? '0 : k_q + 1'b1;
			end else if (cmd.emit) begin
				if (j_q == c_last) begin
					j_q <= '0;
					i_q <= i_q + 1'b1;
				end else begin
					j_q <= j_q + 1'b1;
				end
			end
		end
	end

endmodule

// ===== hdl/mme_datapath.sv =====
module mme_datapath (
	input  logic                              clk,
	input  logic                              arst_n,
	input  mme_pkg::cmd_t                     cmd,
	input  logic signed [mme_pkg::VAL_W-1:0]  value,
	output mme_pkg::stat_t                    stat,
	input  logic                              out_ready,
	output logic                              out_valid,
	output mme_pkg::out_item_t                out_item
);

	localparam int DEPTH = mme_pkg::MAX_DIM * mme_pkg::MAX_DIM;

	typedef struct packed {
		logic valid;
		logic first;
		logic lastk;
	} tag_t;

	logic signed [mme_pkg::ELEM_WIDTH-1:0] a_store_q [DEPTH];
	logic signed [mme_pkg::ELEM_WIDTH-1:0] b_store_q [DEPTH];
	logic signed [mme_pkg::ELEM_WIDTH-1:0] rd_a_s1, rd_b_s1;
	logic signed [mme_pkg::MUL_W-1:0]      prod_s2;
	logic signed [mme_pkg::PROD_W-1:0]     acc_q, prod_ext;
	logic signed [mme_pkg::ELEM_WIDTH-1:0] wr_val;
	tag_t                                  tag_s1, tag_s2;
	logic                                  sum_ready_q, out_valid_q;
	mme_pkg::out_item_t                    out_q;

	assign wr_val   = mme_pkg::ELEM_WIDTH'(value);
	assign prod_ext = mme_pkg::PROD_W'(prod_s2);

	always_ff @(posedge clk) begin
		if (cmd.load_a) a_store_q[cmd.wr_addr] <= wr_val;
		rd_a_s1 <= a_store_q[cmd.rd_a_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.load_b) b_store_q[cmd.wr_addr] <= wr_val;
		rd_b_s1 <= b_store_q[cmd.rd_b_addr];
	end

	always_ff @(posedge clk) begin
		prod_s2 <= rd_a_s1 * rd_b_s1;
		if (tag_s2.valid) begin
			acc_q <= tag_s2.first ? prod_ext : acc_q + prod_ext;
		end
		if (cmd.emit) begin
			out_q.out_row       <= cmd.emit_row;
			out_q.out_col       <= cmd.emit_col;
			out_q.product_value <= acc_q;
			out_q.last          <= cmd.emit_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1      <= '0;
			tag_s2      <= '0;
			sum_ready_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			tag_s1      <= '{valid: cmd.issue, first: cmd.first, lastk: cmd.lastk};
			tag_s2      <= tag_s1;
			sum_ready_q <= tag_s2.valid && tag_s2.lastk;
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign stat.sum_ready = sum_ready_q;
	assign stat.out_free  = !out_valid_q || out_ready;
	assign out_valid      = out_valid_q;
	assign out_item       = out_q;

endmodule
